/* rtl/smc_pkg.sv */
// stepper motion controller package: item and register types, command and
// register codes, reset values and coil phase tables
// no dependencies
package smc_pkg;

    // position counter width default
    localparam int POS_BITS_DEF = 16;

    // command codes carried in tuser
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_JOG_IN   = 3'd1;
    localparam logic [2:0] ACT_JOG_OUT  = 3'd2;
    localparam logic [2:0] ACT_FAST_JOG = 3'd3;
    localparam logic [2:0] ACT_REL_MOVE = 3'd4;
    localparam logic [2:0] ACT_ABS_MOVE = 3'd5;
    localparam logic [2:0] ACT_STOP     = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_JOG_DELAY      = 3'd0;
    localparam logic [2:0] REG_FAST_JOG_DELAY = 3'd1;
    localparam logic [2:0] REG_AUTO_DELAY     = 3'd2;
    localparam logic [2:0] REG_LIMIT_LOW      = 3'd3;
    localparam logic [2:0] REG_LIMIT_HIGH     = 3'd4;
    localparam logic [2:0] REG_BACKLASH       = 3'd5;
    localparam logic [2:0] REG_STEP_MODE      = 3'd6;
    localparam logic [2:0] REG_DRIVE_OPTIONS  = 3'd7;

    // step modes
    localparam logic [1:0] MODE_HALF   = 2'd0;
    localparam logic [1:0] MODE_FULL   = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd2;

    // register reset values
    localparam logic [15:0] RST_JOG_DELAY      = 16'd50;
    localparam logic [15:0] RST_FAST_JOG_DELAY = 16'd10;
    localparam logic [15:0] RST_AUTO_DELAY     = 16'd10;
    localparam logic [15:0] RST_LIMIT_LOW      = 16'd0;
    localparam logic [15:0] RST_LIMIT_HIGH     = 16'd10000;
    localparam logic [15:0] RST_BACKLASH       = 16'd0;
    localparam logic [1:0]  RST_STEP_MODE      = MODE_FULL;
    localparam logic [1:0]  RST_DRIVE_OPTIONS  = 2'd0;
    localparam logic [15:0] RST_ACTIVE_DELAY   = 16'd10;

    // configuration registers as seen by the core
    typedef struct packed {
        logic [15:0] jog_delay;
        logic [15:0] fast_jog_delay;
        logic [15:0] auto_delay;
        logic [15:0] limit_low;
        logic [15:0] limit_high;
        logic [15:0] backlash_steps;
        logic [1:0]  step_mode;
        logic [1:0]  drive_options;
    } cfg_t;

    // one input item
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] amount;
        logic        move_dir;
        logic        force_stop;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [3:0]  coils;
        logic        drive_enable;
        logic        moving;
        logic [15:0] position;
        logic        stopped_pulse;
    } res_t;

    // half-step coil pattern
    function automatic logic [3:0] half_coils(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0:    c = 4'h2;
            3'd1:    c = 4'hA;
            3'd2:    c = 4'h8;
            3'd3:    c = 4'h9;
            3'd4:    c = 4'h1;
            3'd5:    c = 4'h5;
            3'd6:    c = 4'h4;
            default: c = 4'h6;
        endcase
        return c;
    endfunction

    // two-coil full-step pattern
    function automatic logic [3:0] full_coils(input logic [1:0] idx);
        logic [3:0] c;
        case (idx)
            2'd0:    c = 4'hA;
            2'd1:    c = 4'h6;
            2'd2:    c = 4'h5;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    // single-coil low-power pattern
    function automatic logic [3:0] single_coils(input logic [1:0] idx);
        logic [3:0] c;
        case (idx)
            2'd0:    c = 4'h2;
            2'd1:    c = 4'h4;
            2'd2:    c = 4'h1;
            default: c = 4'h8;
        endcase
        return c;
    endfunction

endpackage

/* rtl/smc_cfg_regs.sv */
// configuration register file of the stepper motion controller
// depends on smc_pkg
module smc_cfg_regs
    import smc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_JOG_DELAY:      cfg_next.jog_delay      = cfg_data;
                REG_FAST_JOG_DELAY: cfg_next.fast_jog_delay = cfg_data;
                REG_AUTO_DELAY:     cfg_next.auto_delay     = cfg_data;
                REG_LIMIT_LOW:      cfg_next.limit_low      = cfg_data;
                REG_LIMIT_HIGH:     cfg_next.limit_high     = cfg_data;
                REG_BACKLASH:       cfg_next.backlash_steps = cfg_data;
                REG_STEP_MODE:      cfg_next.step_mode      = cfg_data[1:0];
                REG_DRIVE_OPTIONS:  cfg_next.drive_options  = cfg_data[1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jog_delay      <= RST_JOG_DELAY;
            cfg_reg.fast_jog_delay <= RST_FAST_JOG_DELAY;
            cfg_reg.auto_delay     <= RST_AUTO_DELAY;
            cfg_reg.limit_low      <= RST_LIMIT_LOW;
            cfg_reg.limit_high     <= RST_LIMIT_HIGH;
            cfg_reg.backlash_steps <= RST_BACKLASH;
            cfg_reg.step_mode      <= RST_STEP_MODE;
            cfg_reg.drive_options  <= RST_DRIVE_OPTIONS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/smc_core.sv */
// motion state of the stepper controller and the per-item update logic
// depends on smc_pkg
module smc_core
    import smc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  cmd_t cmd,
    input  cfg_t cfg,
    output res_t res
);

    localparam int CMP_W = (POS_BITS > 16) ? POS_BITS : 16;

    logic                is_moving_reg, is_moving_next;
    logic                manual_mode_reg, manual_mode_next;
    logic                last_dir_reg, last_dir_next;
    logic                stop_pending_reg, stop_pending_next;
    logic                drive_on_reg, drive_on_next;
    logic [2:0]          phase_reg, phase_next;
    logic [3:0]          coil_reg, coil_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] target_reg, target_next;
    logic [15:0]         backlash_reg, backlash_next;
    logic [15:0]         countdown_reg, countdown_next;
    logic [15:0]         delay_reg, delay_next;
    logic                pulse;

    // next state for the item in the input stage
    always_comb
    begin
        logic                start;
        logic                dir_outward;
        logic                stop_now;
        logic [2:0]          mask;
        logic [2:0]          idx;
        logic                inc;
        logic [15:0]         limit;
        logic [POS_BITS-1:0] amt;
        logic [15:0]         bl_dec;

        is_moving_next    = is_moving_reg;
        manual_mode_next  = manual_mode_reg;
        last_dir_next     = last_dir_reg;
        stop_pending_next = stop_pending_reg;
        drive_on_next     = drive_on_reg;
        phase_next        = phase_reg;
        coil_next         = coil_reg;
        pos_next          = pos_reg;
        target_next       = target_reg;
        backlash_next     = backlash_reg;
        countdown_next    = countdown_reg;
        delay_next        = delay_reg;
        pulse             = 1'b0;
        start             = 1'b0;
        dir_outward       = 1'b0;
        stop_now          = 1'b0;

        mask   = (cfg.step_mode == MODE_HALF) ? 3'd7 : 3'd3;
        inc    = (!last_dir_reg) ^ cfg.drive_options[0];
        idx    = phase_reg & mask;
        limit  = last_dir_reg ? cfg.limit_high : cfg.limit_low;
        amt    = POS_BITS'(CMP_W'(cmd.amount));
        bl_dec = backlash_reg - 16'd1;

        case (cmd.action)
            ACT_TICK:
            begin
                if (is_moving_reg)
                begin
                    if (countdown_reg <= 16'd1)
                    begin
                        countdown_next = delay_reg;
                        // advance the coil phase
                        idx = inc ? ((idx + 3'd1) & mask) : ((idx + mask) & mask);
                        phase_next = idx;
                        case (cfg.step_mode)
                            MODE_HALF:   coil_next = half_coils(idx);
                            MODE_SINGLE: coil_next = single_coils(idx[1:0]);
                            default:     coil_next = full_coils(idx[1:0]);
                        endcase
                        // destination, limit, backlash or position
                        if ((!manual_mode_reg && pos_reg == target_reg) ||
                            (CMP_W'(pos_reg) == CMP_W'(limit)))
                        begin
                            stop_now = 1'b1;
                        end
                        else if (backlash_reg != 16'd0)
                        begin
                            backlash_next = bl_dec;
                            if (stop_pending_reg && bl_dec == 16'd0)
                            begin
                                stop_now = 1'b1;
                            end
                        end
                        else if (last_dir_reg)
                        begin
                            pos_next = pos_reg + POS_BITS'(1);
                        end
                        else
                        begin
                            pos_next = pos_reg - POS_BITS'(1);
                        end
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                end
            end
            ACT_JOG_IN, ACT_JOG_OUT:
            begin
                manual_mode_next  = 1'b1;
                stop_pending_next = 1'b0;
                delay_next        = cfg.jog_delay;
                start             = 1'b1;
                dir_outward       = (cmd.action == ACT_JOG_OUT);
            end
            ACT_FAST_JOG:
            begin
                delay_next = cfg.fast_jog_delay;
            end
            ACT_REL_MOVE:
            begin
                manual_mode_next  = 1'b0;
                stop_pending_next = 1'b0;
                delay_next        = cfg.auto_delay;
                target_next       = cmd.move_dir ? (pos_reg + amt) : (pos_reg - amt);
                start             = 1'b1;
                dir_outward       = cmd.move_dir;
            end
            ACT_ABS_MOVE:
            begin
                manual_mode_next  = 1'b0;
                stop_pending_next = 1'b0;
                delay_next        = cfg.auto_delay;
                target_next       = amt;
                start             = (amt != pos_reg);
                dir_outward       = (amt > pos_reg);
            end
            ACT_STOP:
            begin
                if (is_moving_reg && manual_mode_reg && !cmd.force_stop &&
                    backlash_reg != 16'd0)
                begin
                    stop_pending_next = 1'b1;
                end
                else
                begin
                    stop_now = 1'b1;
                end
            end
            default:
            begin
                pulse = 1'b0;
            end
        endcase

        // start a move in the chosen direction
        if (start)
        begin
            if (last_dir_reg != dir_outward && backlash_reg == 16'd0)
            begin
                backlash_next = cfg.backlash_steps;
            end
            last_dir_next  = dir_outward;
            drive_on_next  = 1'b1;
            is_moving_next = 1'b1;
            countdown_next = delay_next;
        end

        // end of motion
        if (stop_now)
        begin
            if (!cfg.drive_options[1])
            begin
                drive_on_next = 1'b0;
            end
            stop_pending_next = 1'b0;
            pulse             = is_moving_reg;
            is_moving_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_moving_reg    <= 1'b0;
            manual_mode_reg  <= 1'b0;
            last_dir_reg     <= 1'b0;
            stop_pending_reg <= 1'b0;
            drive_on_reg     <= 1'b0;
            phase_reg        <= 3'd0;
            coil_reg         <= 4'd0;
            pos_reg          <= '0;
            target_reg       <= '0;
            backlash_reg     <= 16'd0;
            countdown_reg    <= 16'd0;
            delay_reg        <= RST_ACTIVE_DELAY;
        end
        else if (step_en)
        begin
            is_moving_reg    <= is_moving_next;
            manual_mode_reg  <= manual_mode_next;
            last_dir_reg     <= last_dir_next;
            stop_pending_reg <= stop_pending_next;
            drive_on_reg     <= drive_on_next;
            phase_reg        <= phase_next;
            coil_reg         <= coil_next;
            pos_reg          <= pos_next;
            target_reg       <= target_next;
            backlash_reg     <= backlash_next;
            countdown_reg    <= countdown_next;
            delay_reg        <= delay_next;
        end
    end

    // result reflects the state after the item
    assign res.coils         = coil_next;
    assign res.drive_enable  = drive_on_next;
    assign res.moving        = is_moving_next;
    assign res.position      = 16'(CMP_W'(pos_next));
    assign res.stopped_pulse = pulse;

    // a pending stop only exists during a jog
    assert property (@(posedge clk) disable iff (!rst_n)
        stop_pending_reg |-> (is_moving_reg && manual_mode_reg))
        else $error("stop pending outside a running jog");

    // moving always keeps the driver enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        is_moving_reg |-> drive_on_reg)
        else $error("moving with driver disabled");

    // a pending stop always waits on remaining backlash
    assert property (@(posedge clk) disable iff (!rst_n)
        stop_pending_reg |-> (backlash_reg != 16'd0))
        else $error("stop pending with no backlash left");

endmodule

/* rtl/stepper_motion_controller.sv */
// stepper motion controller: one result item per command item; a command passes
// through the input register and then the result register, and m_tvalid rises as the result register loads
// one item per cycle sustained while m_tready stays high, set by the combinational update between the input
// register and the result register; a low m_tready while a result waits holds both registers
// reset (rst_n low, asynchronous) clears motion state and loads register defaults
// depends on smc_pkg, smc_cfg_regs, smc_core
module stepper_motion_controller
    import smc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // amount[15:0], move_dir, force_stop, zero pad
    input  logic [2:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // coils[3:0], drive_enable, moving, position[15:0],
                                   // stopped_pulse, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg;
    cmd_t cmd_reg, cmd_next;
    res_t res;
    res_t res_reg;
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s_accept;
    logic advance;

    smc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smc_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .cmd     (cmd_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // stage handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        cmd_next.action     = s_tuser;
        cmd_next.amount     = s_tdata[15:0];
        cmd_next.move_dir   = s_tdata[16];
        cmd_next.force_stop = s_tdata[17];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg <= cmd_next;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.stopped_pulse, res_reg.position, res_reg.moving,
                       res_reg.drive_enable, res_reg.coils};

    // an item in the input stage moves on when the result slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input item did not advance into a free result slot");

    // a stop pulse reports motion that has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.stopped_pulse) |-> !res_reg.moving)
        else $error("stop pulse while still moving");

    // a moving result always has the driver enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.moving) |-> res_reg.drive_enable)
        else $error("moving result with driver disabled");

endmodule

/* dv/stepper_motion_controller_checker.sv */
`timescale 1ns / 100ps
// status checker for the stepper motion controller: tracks commands, register
// writes and status items, predicts each status item and compares it field by field
// depends on smc_pkg
module stepper_motion_controller_checker
    import smc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // amount[15:0], move_dir, force_stop, zero pad
    input  logic [2:0]  s_tuser,   // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // coils[3:0], drive_enable, moving, position[15:0],
                                   // stopped_pulse, zero pad
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);

    // coil patterns, phase 0 in the lowest nibble
    localparam logic [31:0] HALF_SEQ   = 32'h6451_98A2;
    localparam logic [15:0] FULL_SEQ   = 16'h956A;
    localparam logic [15:0] SINGLE_SEQ = 16'h8142;

    // register copies
    logic [15:0] r_jog, r_fast, r_auto, r_low, r_high, r_backlash;
    logic [1:0]  r_mode, r_opts;

    // motion state
    logic        run_on, jog_mode, heading_out, halt_pending, drive_hold;
    logic [2:0]  phase_idx;
    logic [3:0]  coil_pat;
    logic [15:0] pos_q, target_q, backlash_q, countdown_q, delay_q;

    // predicted status items in command order
    res_t status_q[$];

    function automatic void reset_predictor();
        r_jog        = RST_JOG_DELAY;
        r_fast       = RST_FAST_JOG_DELAY;
        r_auto       = RST_AUTO_DELAY;
        r_low        = RST_LIMIT_LOW;
        r_high       = RST_LIMIT_HIGH;
        r_backlash   = RST_BACKLASH;
        r_mode       = RST_STEP_MODE;
        r_opts       = RST_DRIVE_OPTIONS;
        run_on       = 1'b0;
        jog_mode     = 1'b0;
        heading_out  = 1'b0;
        halt_pending = 1'b0;
        drive_hold   = 1'b0;
        phase_idx    = 3'd0;
        coil_pat     = 4'h0;
        pos_q        = 16'd0;
        target_q     = 16'd0;
        backlash_q   = 16'd0;
        countdown_q  = 16'd0;
        delay_q      = RST_ACTIVE_DELAY;
    endfunction

    function automatic void load_register(logic [2:0] idx, logic [15:0] value);
        case (idx)
            REG_JOG_DELAY:      r_jog      = value;
            REG_FAST_JOG_DELAY: r_fast     = value;
            REG_AUTO_DELAY:     r_auto     = value;
            REG_LIMIT_LOW:      r_low      = value;
            REG_LIMIT_HIGH:     r_high     = value;
            REG_BACKLASH:       r_backlash = value;
            REG_STEP_MODE:      r_mode     = value[1:0];
            default:            r_opts     = value[1:0];
        endcase
    endfunction

    // end of motion; true only when a motion was actually running
    function automatic logic halt_motion();
        if (!r_opts[1])
            drive_hold = 1'b0;
        halt_pending = 1'b0;
        if (!run_on)
            return 1'b0;
        run_on = 1'b0;
        return 1'b1;
    endfunction

    // a reversal reloads the backlash take-up unless some is still left
    function automatic void start_travel(logic outward);
        if (heading_out != outward && backlash_q == 16'd0)
            backlash_q = r_backlash;
        heading_out = outward;
        drive_hold  = 1'b1;
        run_on      = 1'b1;
        countdown_q = delay_q;
    endfunction

    // one motor step: new coil phase, then stop, take up backlash or count
    function automatic logic advance_phase();
        logic [2:0]  mask;
        logic        fwd;
        logic [2:0]  idx;
        logic [15:0] lim;
        mask = (r_mode == MODE_HALF) ? 3'd7 : 3'd3;
        fwd  = (!heading_out) != r_opts[0];
        idx  = phase_idx & mask;
        lim  = heading_out ? r_high : r_low;
        idx  = fwd ? ((idx + 3'd1) & mask) : ((idx + mask) & mask);
        phase_idx = idx;
        if (r_mode == MODE_HALF)
            coil_pat = HALF_SEQ[{idx, 2'b00} +: 4];
        else if (r_mode == MODE_SINGLE)
            coil_pat = SINGLE_SEQ[{idx[1:0], 2'b00} +: 4];
        else
            coil_pat = FULL_SEQ[{idx[1:0], 2'b00} +: 4];

        if ((!jog_mode && pos_q == target_q) || pos_q == lim)
            return halt_motion();
        if (backlash_q != 16'd0) begin
            backlash_q = backlash_q - 16'd1;
            if (halt_pending && backlash_q == 16'd0)
                return halt_motion();
        end
        else if (heading_out)
            pos_q = pos_q + 16'd1;
        else
            pos_q = pos_q - 16'd1;
        return 1'b0;
    endfunction

    // status item caused by one command item
    function automatic res_t apply_command(cmd_t c);
        res_t r;
        logic ended;
        ended = 1'b0;
        case (c.action)
            ACT_TICK:
                if (run_on) begin
                    if (countdown_q <= 16'd1) begin
                        countdown_q = delay_q;
                        ended = advance_phase();
                    end
                    else
                        countdown_q = countdown_q - 16'd1;
                end
            ACT_JOG_IN, ACT_JOG_OUT:
            begin
                jog_mode     = 1'b1;
                halt_pending = 1'b0;
                delay_q      = r_jog;
                start_travel(c.action == ACT_JOG_OUT);
            end
            ACT_FAST_JOG:
                delay_q = r_fast;
            ACT_REL_MOVE:
            begin
                jog_mode     = 1'b0;
                halt_pending = 1'b0;
                delay_q      = r_auto;
                target_q     = c.move_dir ? pos_q + c.amount : pos_q - c.amount;
                start_travel(c.move_dir);
            end
            ACT_ABS_MOVE:
            begin
                jog_mode     = 1'b0;
                halt_pending = 1'b0;
                delay_q      = r_auto;
                target_q     = c.amount;
                if (target_q < pos_q)
                    start_travel(1'b0);
                else if (target_q > pos_q)
                    start_travel(1'b1);
            end
            ACT_STOP:
                if (run_on && jog_mode && !c.force_stop && backlash_q != 16'd0)
                    halt_pending = 1'b1;
                else
                    ended = halt_motion();
            default: ;
        endcase
        r.coils         = coil_pat;
        r.drive_enable  = drive_hold;
        r.moving        = run_on;
        r.position      = pos_q;
        r.stopped_pulse = ended;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // compare leaving status items, then take in register writes and commands
    always @(posedge clk or negedge rst_n) begin : monitor
        cmd_t cmd;
        res_t want;
        if (!rst_n) begin
            reset_predictor();
            status_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $error("status item %h with none expected", m_tdata);
                    fail_count++;
                end
                else begin
                    want = status_q.pop_front();
                    check_field("coils", int'(want.coils), int'(m_tdata[3:0]));
                    check_field("drive_enable", int'(want.drive_enable), int'(m_tdata[4]));
                    check_field("moving", int'(want.moving), int'(m_tdata[5]));
                    check_field("position", int'(want.position), int'(m_tdata[21:6]));
                    check_field("stopped_pulse", int'(want.stopped_pulse),
                                int'(m_tdata[22]));
                end
            end
            if (cfg_valid && cfg_ready)
                load_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                cmd.action     = s_tuser;
                cmd.amount     = s_tdata[15:0];
                cmd.move_dir   = s_tdata[16];
                cmd.force_stop = s_tdata[17];
                status_q.push_back(apply_command(cmd));
            end
            outstanding = status_q.size();
        end
    end

endmodule

/* dv/stepper_motion_controller_tb.sv */
`timescale 1ns / 100ps
// testbench top for the stepper motion controller: clock, reset, command and
// register stimulus, random backpressure and the final verdict
// depends on smc_pkg, stepper_motion_controller, stepper_motion_controller_checker
module stepper_motion_controller_tb;
    import smc_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 240;
    localparam logic [2:0]  ACT_UNUSED    = 3'd7;
    localparam logic [1:0]  MODE_FULL_ALT = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    int          sent_items  = 0;
    int          no_gap_left = 0;
    logic [15:0] cur_low     = RST_LIMIT_LOW;
    logic [15:0] cur_high    = RST_LIMIT_HIGH;

    stepper_motion_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stepper_motion_controller_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("stepper_motion_controller_tb: FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // status sink: random stalls with occasional long ready stretches
    initial
    begin : sink
        int hold;
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
            m_tready = 1'b1;
            repeat (hold) @(negedge clk);
            stall = pick_gap();
            if (stall == 0)
                stall = 1;
            m_tready = 1'b0;
            repeat (stall) @(negedge clk);
        end
    end

    // one command item; called at a falling edge, returns at a falling edge
    task automatic send_cmd(logic [2:0] act, logic [15:0] amt, logic dir, logic frc);
        int gap;
        gap = (no_gap_left > 0) ? 0 : pick_gap();
        if (no_gap_left > 0)
            no_gap_left--;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {6'd0, frc, dir, amt};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent_items++;
    endtask

    // register write; cfg_valid is left high for back-to-back writes
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // hold commands back until every status item has left the block
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_setting(logic [15:0] jog, logic [15:0] fast, logic [15:0] auto_d,
                                 logic [15:0] low, logic [15:0] high, logic [15:0] back,
                                 logic [1:0] mode, logic [1:0] opts);
        write_reg(REG_JOG_DELAY, jog);
        write_reg(REG_FAST_JOG_DELAY, fast);
        write_reg(REG_AUTO_DELAY, auto_d);
        write_reg(REG_LIMIT_LOW, low);
        write_reg(REG_LIMIT_HIGH, high);
        write_reg(REG_BACKLASH, back);
        write_reg(REG_STEP_MODE, {14'd0, mode});
        write_reg(REG_DRIVE_OPTIONS, {14'd0, opts});
        cfg_valid = 1'b0;
        cur_low   = low;
        cur_high  = high;
    endtask

    // one random command followed by a run of ticks; now and then a lone item
    task automatic run_sequence();
        int          r;
        int          ticks;
        logic [2:0]  act;
        logic [15:0] amt;
        r   = $urandom_range(0, 99);
        amt = 16'($urandom);
        if (r < 15)
            act = ACT_JOG_IN;
        else if (r < 30)
            act = ACT_JOG_OUT;
        else if (r < 38)
            act = ACT_FAST_JOG;
        else if (r < 60)
            act = ACT_REL_MOVE;
        else if (r < 75)
            act = ACT_ABS_MOVE;
        else if (r < 95)
            act = ACT_STOP;
        else if (r < 98)
            act = ACT_UNUSED;
        else
            act = ACT_TICK;

        r = $urandom_range(0, 9);
        if (act == ACT_REL_MOVE) begin
            if (r < 7)
                amt = 16'($urandom_range(0, 24));
            else if (r == 7)
                amt = 16'd0;
            else if (r == 8)
                amt = 16'hFFFF;
        end
        else if (act == ACT_ABS_MOVE) begin
            if (r < 6)
                amt = 16'($urandom_range(cur_low, cur_high));
            else if (r == 6)
                amt = 16'd0;
            else if (r == 7)
                amt = 16'hFFFF;
        end
        send_cmd(act, amt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

        if ($urandom_range(0, 9) == 0)
            ticks = 0;
        else if ($urandom_range(0, 3) == 0)
            ticks = $urandom_range(1, 3);
        else
            ticks = $urandom_range(4, 40);
        repeat (ticks)
            send_cmd(ACT_TICK, 16'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int phase_end;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 24'd0;
        s_tuser   = ACT_TICK;
        cfg_valid = 1'b0;
        cfg_index = REG_JOG_DELAY;
        cfg_data  = 16'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: idle cases under reset settings
        send_cmd(ACT_TICK, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_UNUSED, 16'hFFFF, 1'b1, 1'b1);
        send_cmd(ACT_STOP, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_ABS_MOVE, 16'd0, 1'b0, 1'b0);
        drain();

        // directed: backlash take-up, pending stop, limit, forced stop
        apply_setting(16'd1, 16'd2, 16'd1, 16'd0, 16'd5, 16'd2, MODE_HALF, 2'd3);
        send_cmd(ACT_JOG_OUT, 16'd0, 1'b0, 1'b0);
        repeat (4) send_cmd(ACT_TICK, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_FAST_JOG, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_JOG_IN, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_STOP, 16'd0, 1'b0, 1'b0);
        repeat (2) send_cmd(ACT_TICK, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_REL_MOVE, 16'd9, 1'b1, 1'b0);
        repeat (5) send_cmd(ACT_TICK, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_ABS_MOVE, 16'hFFFF, 1'b0, 1'b0);
        send_cmd(ACT_TICK, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_ABS_MOVE, 16'd0, 1'b0, 1'b0);
        send_cmd(ACT_STOP, 16'd0, 1'b0, 1'b1);
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_setting(16'd1, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd0,
                                 MODE_HALF, 2'd0);
                1: apply_setting(16'd2, 16'd1, 16'd3, 16'd100, 16'd140, 16'd3,
                                 MODE_FULL, 2'd1);
                2: apply_setting(16'hFFFF, 16'd1, 16'd2, 16'hFFFF, 16'd0, 16'hFFFF,
                                 MODE_SINGLE, 2'd2);
                3: apply_setting(16'd1, 16'd2, 16'd1, 16'd20, 16'd30, 16'd1,
                                 MODE_FULL_ALT, 2'd3);
                default:
                    apply_setting(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                                  16'($urandom_range(1, 4)), 16'($urandom_range(0, 40)),
                                  16'($urandom_range(60, 200)), 16'($urandom_range(0, 6)),
                                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            endcase
            no_gap_left = $urandom_range(30, 80);
            phase_end   = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end) begin
                run_sequence();
                // mid-phase pause until the block has emptied
                if (p == 4 && sent_items >= phase_end - PHASE_ITEMS / 2
                    && sent_items < phase_end - PHASE_ITEMS / 2 + 40)
                    drain();
            end
            drain();
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("stepper_motion_controller_tb: PASS");
        else
            $display("stepper_motion_controller_tb: FAIL");
        $finish;
    end

endmodule
